/* hw/rtl/rcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP command parser package
// Shared types and constants for the byte-serial RESP command parser.
// ----------------------------------------------------------------------------
package rcp_pkg;

	// Protocol characters.
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Saturation points.
	localparam logic [16:0] ACC_MAX   = 17'h1FFFF;
	localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd1;
	localparam logic [4:0]  MAX_ARGS_RST = 5'd16;
	localparam logic [15:0] MAX_LEN_RST  = 16'd4096;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_COUNT,
		PH_DOLLAR,
		PH_LEN,
		PH_PAYLOAD,
		PH_TERM_CR,
		PH_TERM_LF
	} phase_t;

	// Per-byte command status.
	typedef enum logic [1:0] {
		ST_PENDING  = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	// Parser state carried from byte to byte.
	typedef struct packed {
		phase_t      phase;
		logic [16:0] number_acc;
		logic        number_bad;
		logic        cr_pending;
		logic        digit_seen;
		logic [4:0]  args_left;
		logic [15:0] bytes_left;
		logic [3:0]  current_arg;
		logic [15:0] current_len;
		logic [23:0] byte_count;
	} state_t;

	// Result of one byte.
	typedef struct packed {
		status_t     status;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [3:0]  arg_index;
		logic        arg_done;
		logic [15:0] arg_length;
		logic [23:0] consumed;
	} result_t;

	// State after reset, complete or invalid.
	localparam state_t STATE_IDLE = '{
		phase:       PH_IDLE,
		number_acc:  17'd0,
		number_bad:  1'b0,
		cr_pending:  1'b0,
		digit_seen:  1'b0,
		args_left:   5'd0,
		bytes_left:  16'd0,
		current_arg: 4'd0,
		current_len: 16'd0,
		byte_count:  24'd0
	};

endpackage : rcp_pkg
`default_nettype wire

/* hw/rtl/rcp_byte_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP parser byte channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface rcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface : rcp_byte_if
`default_nettype wire

/* hw/rtl/rcp_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP parser result channel
// Valid/ready channel carrying the parse result of one byte per transaction.
// ----------------------------------------------------------------------------
interface rcp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [3:0]  arg_index;
	logic        arg_done;
	logic [15:0] arg_length;
	logic [23:0] consumed;

	modport source (
		output valid, output status, output payload_valid, output payload_byte,
		output arg_index, output arg_done, output arg_length, output consumed,
		input ready
	);
	modport sink (
		input valid, input status, input payload_valid, input payload_byte,
		input arg_index, input arg_done, input arg_length, input consumed,
		output ready
	);
endinterface : rcp_result_if
`default_nettype wire

/* hw/rtl/rcp_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP parser configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rcp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface : rcp_cfg_if
`default_nettype wire

/* hw/rtl/rcp_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP parser byte step
// Combinational update of the parser state and the result for one byte.
// ----------------------------------------------------------------------------
module rcp_step (
	input  rcp_pkg::state_t  cur,
	input  logic [7:0]       in_byte,
	input  logic [4:0]       cap_args,
	input  logic [15:0]      cap_len,
	output rcp_pkg::state_t  nxt,
	output rcp_pkg::result_t res
);
	import rcp_pkg::*;

	logic [23:0] byte_count_inc;
	logic        is_digit;
	logic [20:0] acc_x10;
	logic [16:0] acc_next;
	logic        nf_done;
	state_t      nf;
	state_t      upd;
	logic [4:0]  args_dec;

	// Saturating byte counter.
	assign byte_count_inc = (cur.byte_count != COUNT_MAX) ? cur.byte_count + 24'd1
		: cur.byte_count;

	// Decimal accumulator, saturating well above every limit.
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign acc_x10  = ({4'd0, cur.number_acc} << 3) + ({4'd0, cur.number_acc} << 1)
		+ {17'd0, 4'(in_byte - CH_ZERO)};
	assign acc_next = (acc_x10 > {4'd0, ACC_MAX}) ? ACC_MAX : acc_x10[16:0];

	// Number line scanner: digits until CRLF, a stray CR marks the line bad.
	always_comb begin
		nf      = cur;
		nf_done = 1'b0;
		if (in_byte == CH_LF && cur.cr_pending) begin
			nf.cr_pending = 1'b0;
			nf_done       = 1'b1;
		end else begin
			nf.number_bad = cur.number_bad | cur.cr_pending;
			nf.cr_pending = 1'b0;
			if (in_byte == CH_CR) begin
				nf.cr_pending = 1'b1;
			end else if (is_digit) begin
				nf.digit_seen = 1'b1;
				nf.number_acc = acc_next;
			end else begin
				nf.number_bad = 1'b1;
			end
		end
	end

	assign args_dec = (cur.args_left != 5'd0) ? cur.args_left - 5'd1 : 5'd0;

	// Phase handling and result fields.
	always_comb begin
		upd                = cur;
		upd.byte_count     = byte_count_inc;
		res.status         = ST_PENDING;
		res.payload_valid  = 1'b0;
		res.payload_byte   = 8'd0;
		res.arg_index      = cur.current_arg;
		res.arg_done       = 1'b0;
		res.arg_length     = 16'd0;
		res.consumed       = byte_count_inc;
		case (cur.phase)
			PH_COUNT: begin
				upd            = nf;
				upd.byte_count = byte_count_inc;
				if (nf_done) begin
					if (!nf.digit_seen || nf.number_bad || nf.number_acc == 17'd0
						|| nf.number_acc > {12'd0, cap_args}) begin
						res.status = ST_INVALID;
					end else begin
						upd.args_left   = nf.number_acc[4:0];
						upd.current_arg = 4'd0;
						upd.phase       = PH_DOLLAR;
					end
				end
			end
			PH_DOLLAR: begin
				if (in_byte == CH_DOLLAR) begin
					upd.number_acc = 17'd0;
					upd.number_bad = 1'b0;
					upd.cr_pending = 1'b0;
					upd.digit_seen = 1'b0;
					upd.phase      = PH_LEN;
				end else begin
					res.status = ST_INVALID;
				end
			end
			PH_LEN: begin
				upd            = nf;
				upd.byte_count = byte_count_inc;
				if (nf_done) begin
					if (!nf.digit_seen || nf.number_bad
						|| nf.number_acc > {1'b0, cap_len}) begin
						res.status = ST_INVALID;
					end else begin
						upd.current_len = nf.number_acc[15:0];
						upd.bytes_left  = nf.number_acc[15:0];
						upd.phase = (nf.number_acc == 17'd0) ? PH_TERM_CR : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = in_byte;
				upd.bytes_left    = cur.bytes_left - 16'd1;
				if (cur.bytes_left == 16'd1) begin
					upd.phase = PH_TERM_CR;
				end
			end
			PH_TERM_CR: begin
				if (in_byte == CH_CR) begin
					upd.phase = PH_TERM_LF;
				end else begin
					res.status = ST_INVALID;
				end
			end
			PH_TERM_LF: begin
				if (in_byte == CH_LF) begin
					res.arg_done   = 1'b1;
					res.arg_length = cur.current_len;
					upd.args_left  = args_dec;
					if (args_dec == 5'd0) begin
						res.status = ST_COMPLETE;
					end else begin
						upd.current_arg = cur.current_arg + 4'd1;
						upd.phase       = PH_DOLLAR;
					end
				end else begin
					res.status = ST_INVALID;
				end
			end
			default: begin
				// Idle: only an array header may start a command.
				if (in_byte == CH_STAR) begin
					upd.number_acc = 17'd0;
					upd.number_bad = 1'b0;
					upd.cr_pending = 1'b0;
					upd.digit_seen = 1'b0;
					upd.phase      = PH_COUNT;
				end else begin
					res.status = ST_INVALID;
				end
			end
		endcase
	end

	// A finished or rejected command drops back to idle.
	assign nxt = (res.status != ST_PENDING) ? STATE_IDLE : upd;

endmodule : rcp_step
`default_nettype wire

/* hw/rtl/resp_command_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RESP command parser
// Byte-serial parser for RESP arrays of bulk strings with per-byte results.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle unless stalled and gives one result per
// byte, in order. Each byte passes through an input register and a result
// register. The state update for a byte is combinational logic between the
// two, which sets the sustained rate at one byte per clock when not stalled.
// While a result waits to be taken, the input register can still take one
// more byte; the input stalls only when both registers are full. The limits
// max_args (index 0) and max_len (index 1) are written over the configuration
// channel, by the user only while no command is in flight; not enforced here.
module resp_command_parser_unit #(
	parameter int ARG_LIMIT = 16,
	parameter int LEN_LIMIT = 65535
) (
	input  logic                clk,
	input  logic                arst_n,
	rcp_byte_if.sink            in_ch,
	rcp_cfg_if.sink             cfg,
	rcp_result_if.source        res
);
	import rcp_pkg::*;

	localparam logic [4:0]  ARG_CAP = 5'(ARG_LIMIT);
	localparam logic [15:0] LEN_CAP = 16'(LEN_LIMIT);

	logic [4:0]  max_args_q;
	logic [15:0] max_len_q;
	logic [4:0]  cap_args;
	logic [15:0] cap_len;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     out_q;
	state_t      state_q;
	state_t      state_nxt;
	result_t     step_res;
	logic        advance;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= MAX_ARGS_RST;
			max_len_q  <= MAX_LEN_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_MAX_ARGS) begin
				max_args_q <= cfg.data[4:0];
			end else if (cfg.index == CFG_MAX_LEN) begin
				max_len_q <= cfg.data;
			end
		end
	end

	assign cap_args = (max_args_q > ARG_CAP) ? ARG_CAP : max_args_q;
	assign cap_len  = (max_len_q > LEN_CAP) ? LEN_CAP : max_len_q;

	// Handshake: the byte in stage 1 moves on when the result register is free or being taken.
	assign advance      = !out_valid_q || res.ready;
	assign in_ch.ready  = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
		end
	end

	rcp_step u_step (
		.cur      (state_q),
		.in_byte  (byte_s1),
		.cap_args (cap_args),
		.cap_len  (cap_len),
		.nxt      (state_nxt),
		.res      (step_res)
	);

	// Parser state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_IDLE;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= step_res;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_q.status;
	assign res.payload_valid = out_q.payload_valid;
	assign res.payload_byte  = out_q.payload_byte;
	assign res.arg_index     = out_q.arg_index;
	assign res.arg_done      = out_q.arg_done;
	assign res.arg_length    = out_q.arg_length;
	assign res.consumed      = out_q.consumed;

`ifndef SYNTHESIS
	// A command completes only on the LF that ends its last argument.
	a_complete_ends_arg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_COMPLETE |-> out_q.arg_done)
		else $error("complete without argument end");

	// Payload bytes never finish a command or an argument.
	a_payload_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.payload_valid |->
		out_q.status == ST_PENDING && !out_q.arg_done)
		else $error("payload byte with final status");

	// After complete or invalid the parser starts over from idle.
	a_return_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && step_res.status != ST_PENDING |=>
		state_q.phase == PH_IDLE && state_q.byte_count == 24'd0)
		else $error("parser did not return to idle");

	// An empty result register never stalls the input side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with free result register");
`endif

endmodule : resp_command_parser_unit
`default_nettype wire
